// ===== src/kts_pkg.sv =====
// kts_pkg: shared types and constants of the keyframe track sampler
// payload structs, controller/datapath command and status structs
// no dependencies
`default_nettype none
package kts_pkg;

  localparam int unsigned MaxKeysDefault = 64;
  localparam int unsigned FracBits       = 16;
  localparam logic [16:0] FactorOne      = 17'h10000;
  localparam logic [6:0]  KeyCountReset  = 7'd1;
  localparam logic [1:0]  RegKeyCountAddr = 2'd0;
  localparam logic [4:0]  DivLastStep    = 5'd16;
  localparam logic [1:0]  CompX          = 2'd0;
  localparam logic [1:0]  CompY          = 2'd1;
  localparam logic [1:0]  CompZ          = 2'd2;
  localparam logic        ModeLoad       = 1'b0;
  localparam logic        ModeSample     = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [5:0]         key_index;
    logic [31:0]        time_value;
    logic signed [31:0] load_x;
    logic signed [31:0] load_y;
    logic signed [31:0] load_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [5:0]         segment_found;
    logic               factor_clamped;
  } out_item_t;

  typedef struct packed {
    logic       wr_en;
    logic       latch_t;
    logic       rd_en;
    logic       div_init;
    logic       hold;
    logic       div_step;
    logic       div_first;
    logic       mul_en;
    logic       acc_en;
    logic [1:0] comp;
  } cmd_t;

  typedef struct packed {
    logic t_ge_a;
    logic t_lt_b;
    logic div_need;
  } sts_t;

endpackage
`default_nettype wire

// ===== src/keyframe_track_sampler_top.sv =====
// keyframe_track_sampler_top: key count register on the apb port, sequencer and datapath
// depends on kts_pkg, kts_ctrl, kts_dp
// load: written in the cycle it is taken, busy stays low, no result
// sample: the last key is checked first; at or past it no segment is searched, else up to
// key count - 1 segments are checked from the search hint on, wrapping to key 0 (segment 0 if
// none matches); then the factor is divided unless not needed and x, y, z are interpolated
// one sample at a time; done_o is a single-cycle strobe, the receiver cannot stall
// reset: async active low, key count 1, search hint 0, key memories undefined until written
`default_nettype none
module keyframe_track_sampler_top import kts_pkg::*; #(
  parameter int unsigned MAX_KEYS = MaxKeysDefault
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  item_i,
  output logic           done_o,
  output out_item_t      result_o,
  input  wire logic      psel,
  input  wire logic      penable,
  input  wire logic      pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  localparam int unsigned IW = $clog2(MAX_KEYS);
  localparam int unsigned CW = $clog2(MAX_KEYS + 1);

  logic [6:0]    key_count_q;
  logic [CW-1:0] n_eff;
  cmd_t          cmd;
  sts_t          sts;
  logic [IW-1:0] rd_addr_a, rd_addr_b, seg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= KeyCountReset;
    end else if (psel && penable && pwrite && pready && paddr == RegKeyCountAddr) begin
      key_count_q <= pwdata[6:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == RegKeyCountAddr) ? {25'd0, key_count_q} : 32'd0;

  always_comb begin
    if (key_count_q == 7'd0) begin
      n_eff = CW'(1);
    end else if (32'(key_count_q) > MAX_KEYS) begin
      n_eff = CW'(MAX_KEYS);
    end else begin
      n_eff = CW'(key_count_q);
    end
  end

  kts_ctrl #(.MAX_KEYS(MAX_KEYS)) u_ctrl (
    .clk_i,
    .rst_ni,
    .start_i     (start),
    .mode_i      (item_i.mode),
    .n_i         (n_eff),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .rd_addr_a_o (rd_addr_a),
    .rd_addr_b_o (rd_addr_b),
    .seg_o       (seg),
    .busy_o      (busy),
    .done_o
  );

  kts_dp #(.MAX_KEYS(MAX_KEYS)) u_dp (
    .clk_i,
    .item_i,
    .cmd_i       (cmd),
    .rd_addr_a_i (rd_addr_a),
    .rd_addr_b_i (rd_addr_b),
    .seg_i       (seg),
    .sts_o       (sts),
    .result_o
  );

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result strobe outside a sample");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy) else $error("more than one transfer per sample");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.mode == ModeLoad) |=> !busy && !done_o)
    else $error("load left the block busy");

  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.mode == ModeSample) |=> busy && !done_o)
    else $error("sample not taken");

endmodule
`default_nettype wire

// ===== src/kts_dp.sv =====
// kts_dp: key memories, segment compare, radix-2 factor divider, interpolation
// multiplier and result registers
// depends on kts_pkg
`default_nettype none
module kts_dp import kts_pkg::*; #(
  parameter int unsigned MAX_KEYS = MaxKeysDefault,
  localparam int unsigned IW = $clog2(MAX_KEYS)
) (
  input  wire logic          clk_i,
  input  wire in_item_t      item_i,
  input  wire cmd_t          cmd_i,
  input  wire logic [IW-1:0] rd_addr_a_i,
  input  wire logic [IW-1:0] rd_addr_b_i,
  input  wire logic [IW-1:0] seg_i,
  output sts_t               sts_o,
  output out_item_t          result_o
);

  logic [31:0] time_mem [MAX_KEYS];
  logic [95:0] val_mem  [MAX_KEYS];

  logic [31:0] t_q, rt_a_q, rt_b_q;
  logic [95:0] rv_a_q, rv_b_q;
  logic [32:0] rem_q;
  logic [31:0] den_q;
  logic [16:0] f_q;
  logic [31:0] prod_q;
  out_item_t   res_q;

  logic        wr_ok;
  logic [32:0] num, dt, num_neg, dt_neg;
  logic [31:0] an, ad;
  logic        zero_case, opp, big;
  logic [32:0] trial;
  logic        ge;
  logic [31:0] v0, v1;
  logic signed [32:0] diff;
  logic signed [50:0] prod;
  logic [31:0] sum;

  assign wr_ok = 32'(item_i.key_index) < MAX_KEYS;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && wr_ok) begin
      time_mem[IW'(item_i.key_index)] <= item_i.time_value;
      val_mem[IW'(item_i.key_index)]  <= {item_i.load_z, item_i.load_y, item_i.load_x};
    end
    if (cmd_i.rd_en) begin
      rt_a_q <= time_mem[rd_addr_a_i];
      rt_b_q <= time_mem[rd_addr_b_i];
      rv_a_q <= val_mem[rd_addr_a_i];
      rv_b_q <= val_mem[rd_addr_b_i];
    end
  end

  assign num     = {1'b0, t_q} - {1'b0, rt_a_q};
  assign dt      = {1'b0, rt_b_q} - {1'b0, rt_a_q};
  assign num_neg = 33'd0 - num;
  assign dt_neg  = 33'd0 - dt;
  assign an      = num[32] ? num_neg[31:0] : num[31:0];
  assign ad      = dt[32] ? dt_neg[31:0] : dt[31:0];
  assign zero_case = cmd_i.hold || (dt == 33'd0) || (num == 33'd0);
  assign opp     = num[32] ^ dt[32];
  assign big     = an > ad;

  assign sts_o.t_ge_a   = t_q >= rt_a_q;
  assign sts_o.t_lt_b   = t_q < rt_b_q;
  assign sts_o.div_need = !zero_case && !opp && !big;

  assign trial = cmd_i.div_first ? rem_q : {rem_q[31:0], 1'b0};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    case (cmd_i.comp)
      CompX:   begin v0 = rv_a_q[31:0];  v1 = rv_b_q[31:0];  end
      CompY:   begin v0 = rv_a_q[63:32]; v1 = rv_b_q[63:32]; end
      CompZ:   begin v0 = rv_a_q[95:64]; v1 = rv_b_q[95:64]; end
      default: begin v0 = '0;            v1 = '0;            end
    endcase
  end

  assign diff = (f_q == 17'd0) ? 33'sd0 : $signed({v1[31], v1} - {v0[31], v0});
  assign prod = $signed({1'b0, f_q}) * diff;
  assign sum  = v0 + prod_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_t) begin
      t_q <= item_i.time_value;
    end
    if (cmd_i.div_init) begin
      rem_q <= {1'b0, an};
      den_q <= ad;
      if (zero_case || opp) begin
        f_q <= '0;
      end else if (big) begin
        f_q <= FactorOne;
      end else begin
        f_q <= '0;
      end
      res_q.factor_clamped <= !zero_case && (opp || big);
      res_q.segment_found  <= 6'(seg_i);
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? (trial - {1'b0, den_q}) : trial;
      f_q   <= {f_q[15:0], ge};
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod[47:16];
    end
    if (cmd_i.acc_en) begin
      case (cmd_i.comp)
        CompX:   res_q.out_x <= sum;
        CompY:   res_q.out_y <= sum;
        CompZ:   res_q.out_z <= sum;
        default: res_q.out_x <= res_q.out_x;
      endcase
    end
  end

  assign result_o = res_q;

endmodule
`default_nettype wire

// ===== src/kts_ctrl.sv =====
// kts_ctrl: sequencer for load, segment search with hint and wrap, divide and
// per-component interpolation
// depends on kts_pkg
`default_nettype none
module kts_ctrl import kts_pkg::*; #(
  parameter int unsigned MAX_KEYS = MaxKeysDefault,
  localparam int unsigned IW = $clog2(MAX_KEYS),
  localparam int unsigned CW = $clog2(MAX_KEYS + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic          mode_i,
  input  wire logic [CW-1:0] n_i,
  input  wire sts_t          sts_i,
  output cmd_t               cmd_o,
  output logic [IW-1:0]      rd_addr_a_o,
  output logic [IW-1:0]      rd_addr_b_o,
  output logic [IW-1:0]      seg_o,
  output logic               busy_o,
  output logic               done_o
);

  localparam logic [3:0] SIdle    = 4'd0;
  localparam logic [3:0] SLastRd  = 4'd1;
  localparam logic [3:0] SLastChk = 4'd2;
  localparam logic [3:0] SSrchRd  = 4'd3;
  localparam logic [3:0] SSrchChk = 4'd4;
  localparam logic [3:0] SValRd   = 4'd5;
  localparam logic [3:0] SDivInit = 4'd6;
  localparam logic [3:0] SDiv     = 4'd7;
  localparam logic [3:0] SMul     = 4'd8;
  localparam logic [3:0] SAcc     = 4'd9;
  localparam logic [3:0] SDone    = 4'd10;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          wrap_q, wrap_d;
  logic          hold_q, hold_d;
  logic [IW-1:0] hint_q, hint_d;
  logic [IW-1:0] seg_q, seg_d;
  logic [4:0]    cnt_q, cnt_d;
  logic [CW:0]   idx_inc;
  logic          hit;

  assign idx_inc = {1'b0, idx_q} + 1'b1;
  assign hit     = wrap_q ? sts_i.t_lt_b : (sts_i.t_ge_a && sts_i.t_lt_b);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    wrap_d      = wrap_q;
    hold_d      = hold_q;
    hint_d      = hint_q;
    seg_d       = seg_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    rd_addr_a_o = '0;
    rd_addr_b_o = '0;
    case (state_q)
      SIdle: begin
        if (start_i) begin
          if (mode_i == ModeSample) begin
            cmd_o.latch_t = 1'b1;
            state_d = SLastRd;
          end else begin
            cmd_o.wr_en = 1'b1;
          end
        end
      end
      SLastRd: begin
        cmd_o.rd_en = 1'b1;
        rd_addr_a_o = IW'(n_i - 1'b1);
        state_d = SLastChk;
      end
      SLastChk: begin
        if (n_i == CW'(1) || sts_i.t_ge_a) begin
          seg_d   = IW'(n_i - 1'b1);
          hold_d  = 1'b1;
          state_d = SValRd;
        end else begin
          hold_d  = 1'b0;
          idx_d   = CW'(hint_q);
          wrap_d  = 1'b0;
          state_d = SSrchRd;
        end
      end
      SSrchRd: begin
        if (!wrap_q) begin
          if (idx_inc < {1'b0, n_i}) begin
            cmd_o.rd_en = 1'b1;
            rd_addr_a_o = IW'(idx_q);
            rd_addr_b_o = IW'(idx_inc);
            state_d = SSrchChk;
          end else begin
            idx_d  = '0;
            wrap_d = 1'b1;
          end
        end else if (idx_q < CW'(hint_q) && idx_inc < {1'b0, n_i}) begin
          cmd_o.rd_en = 1'b1;
          rd_addr_a_o = IW'(idx_q);
          rd_addr_b_o = IW'(idx_inc);
          state_d = SSrchChk;
        end else begin
          seg_d   = '0;
          hint_d  = '0;
          state_d = SValRd;
        end
      end
      SSrchChk: begin
        if (hit) begin
          seg_d   = IW'(idx_q);
          hint_d  = IW'(idx_q);
          state_d = SValRd;
        end else begin
          idx_d   = CW'(idx_inc);
          state_d = SSrchRd;
        end
      end
      SValRd: begin
        cmd_o.rd_en = 1'b1;
        rd_addr_a_o = seg_q;
        rd_addr_b_o = seg_q + 1'b1;
        state_d = SDivInit;
      end
      SDivInit: begin
        cmd_o.div_init = 1'b1;
        cmd_o.hold     = hold_q;
        cnt_d   = '0;
        state_d = sts_i.div_need ? SDiv : SMul;
      end
      SDiv: begin
        cmd_o.div_step  = 1'b1;
        cmd_o.div_first = (cnt_q == 5'd0);
        if (cnt_q == DivLastStep) begin
          cnt_d   = '0;
          state_d = SMul;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      SMul: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.comp   = cnt_q[1:0];
        state_d = SAcc;
      end
      SAcc: begin
        cmd_o.acc_en = 1'b1;
        cmd_o.comp   = cnt_q[1:0];
        if (cnt_q[1:0] == CompZ) begin
          state_d = SDone;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = SMul;
        end
      end
      SDone: begin
        state_d = SIdle;
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      idx_q   <= '0;
      wrap_q  <= 1'b0;
      hold_q  <= 1'b0;
      hint_q  <= '0;
      seg_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      wrap_q  <= wrap_d;
      hold_q  <= hold_d;
      hint_q  <= hint_d;
      seg_q   <= seg_d;
      cnt_q   <= cnt_d;
    end
  end

  assign seg_o  = seg_q;
  assign busy_o = state_q != SIdle;
  assign done_o = state_q == SDone;

endmodule
`default_nettype wire

// ===== bench/tb_keyframe_track_sampler_top.sv =====
// tb_keyframe_track_sampler_top: self-checking bench for the keyframe track sampler
// predicts each sample from its own copy of the key store and search hint, checks every result
// depends on kts_pkg and keyframe_track_sampler_top
`default_nettype none
module tb_keyframe_track_sampler_top;
  import kts_pkg::*;

  localparam int unsigned NumKeys = 64;
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned DrainCycles = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t item_i = '0;
  logic done_o;
  out_item_t result_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  keyframe_track_sampler_top dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [31:0] trk_time [NumKeys];
  logic signed [31:0] trk_val [NumKeys][3];
  logic [5:0] trk_hint;
  logic [6:0] trk_count;

  in_item_t pending_items[$];
  out_item_t expected_samples[$];
  int unsigned mismatches, samples_seen, items_sent, stall_cycles;
  bit quiet;

  function automatic out_item_t sample_track(input logic [31:0] t);
    out_item_t r;
    int unsigned n, s, i;
    bit found;
    longint dt, num, an, ad, f, v0, v1, p, q;
    r = '0;
    n = (trk_count == 0) ? 1 : (trk_count > NumKeys ? NumKeys : trk_count);
    if (n == 1 || t >= trk_time[n-1]) begin
      s = n - 1;
      r.out_x = trk_val[s][0];
      r.out_y = trk_val[s][1];
      r.out_z = trk_val[s][2];
    end else begin
      found = 0;
      s = 0;
      for (i = trk_hint; i + 1 < n && !found; i++) begin
        if (t >= trk_time[i] && t < trk_time[i+1]) begin
          s = i;
          found = 1;
        end
      end
      for (i = 0; i < trk_hint && i + 1 < n && !found; i++) begin
        if (t < trk_time[i+1]) begin
          s = i;
          found = 1;
        end
      end
      trk_hint = found ? s[5:0] : 6'd0;
      dt = longint'(trk_time[s+1]) - longint'(trk_time[s]);
      num = longint'(t) - longint'(trk_time[s]);
      f = 0;
      if (dt != 0 && num != 0) begin
        if ((num < 0) != (dt < 0)) begin
          r.factor_clamped = 1'b1;
        end else begin
          an = num < 0 ? -num : num;
          ad = dt < 0 ? -dt : dt;
          if (an > ad) begin
            f = 65536;
            r.factor_clamped = 1'b1;
          end else begin
            f = (an * 65536) / ad;
          end
        end
      end
      for (i = 0; i < 3; i++) begin
        v0 = trk_val[s][i];
        v1 = trk_val[s+1][i];
        p = f * (v1 - v0);
        q = (p >= 0) ? p / 65536 : -((-p + 65535) / 65536);
        if (i == 0) r.out_x = 32'(v0 + q);
        else if (i == 1) r.out_y = 32'(v0 + q);
        else r.out_z = 32'(v0 + q);
      end
    end
    r.segment_found = s[5:0];
    return r;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        if (item_i.mode == ModeLoad) begin
          trk_time[item_i.key_index] <= item_i.time_value;
          trk_val[item_i.key_index][0] <= item_i.load_x;
          trk_val[item_i.key_index][1] <= item_i.load_y;
          trk_val[item_i.key_index][2] <= item_i.load_z;
        end else begin
          expected_samples.push_back(sample_track(item_i.time_value));
        end
        items_sent <= items_sent + 1;
      end
      if (!(start && busy)) begin
        if (pending_items.size() > 0 && !quiet && ($urandom_range(99) >= 30 || items_sent > 300
            && items_sent < 500)) begin
          start <= 1'b1;
          item_i <= pending_items.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      samples_seen <= samples_seen + 1;
      if (expected_samples.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result %p", result_o);
      end else if (result_o !== expected_samples[0]) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10)
          $display("mismatch: expected %p actual %p", expected_samples[0], result_o);
        void'(expected_samples.pop_front());
      end else begin
        void'(expected_samples.pop_front());
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || psel) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > StallLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_count(input logic [6:0] v);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= RegKeyCountAddr; pwdata <= 32'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    trk_count = v;
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || start || expected_samples.size() > 0 || busy)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic in_item_t key_item(input int k, input logic [31:0] t);
    in_item_t it;
    it.mode = ModeLoad;
    it.key_index = 6'(k);
    it.time_value = t;
    it.load_x = $urandom();
    it.load_y = $urandom();
    it.load_z = $urandom();
    return it;
  endfunction

  function automatic in_item_t sample_item(input logic [31:0] t);
    in_item_t it;
    it.mode = ModeSample;
    it.key_index = 6'($urandom());
    it.time_value = t;
    it.load_x = $urandom();
    it.load_y = $urandom();
    it.load_z = $urandom();
    return it;
  endfunction

  function automatic logic [31:0] trk_time_hint(input logic [5:0] k);
    return trk_time[k];
  endfunction

  // sample times mostly inside the loaded track, a bit past both ends
  function automatic logic [31:0] last_span(input int unsigned n);
    logic [31:0] hi;
    hi = trk_time[n-1];
    return (hi > 32'hf000_0000) ? 32'hffff_ffff : hi + (hi >> 4) + 32'd16;
  endfunction

  // random non-decreasing track of n keys, all slots in use get written
  task automatic load_track(input int n, input bit wide);
    logic [31:0] t;
    t = wide ? 32'($urandom_range(3)) : 32'($urandom_range(1000));
    for (int k = 0; k < n; k++) begin
      pending_items.push_back(key_item(k, t));
      if (wide) t = t + 32'($urandom_range(32'h3fff_ffff / (n + 1)));
      else if ($urandom_range(9) == 0) t = t;
      else t = t + 32'($urandom_range(5000, 1));
    end
  endtask

  int unsigned n_cur;
  in_item_t dir_item;

  initial begin
    trk_hint = '0;
    trk_count = KeyCountReset;
    mismatches = 0; samples_seen = 0; items_sent = 0; stall_cycles = 0; quiet = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extreme values, single key, before/after track, equal times, full slot range
    dir_item = key_item(0, 32'd0);
    dir_item.load_x = 32'h8000_0000;
    dir_item.load_y = 32'h7fff_ffff;
    pending_items.push_back(dir_item);
    pending_items.push_back(sample_item(32'hffff_ffff));
    pending_items.push_back(sample_item(32'd0));
    wait_idle();
    write_count(7'd0);
    pending_items.push_back(sample_item(32'h1234));
    dir_item = key_item(1, 32'h0000_0000);
    dir_item.load_x = 32'h7fff_ffff;
    dir_item.load_y = 32'h8000_0000;
    pending_items.push_back(dir_item);
    pending_items.push_back(key_item(2, 32'h0001_0000));
    pending_items.push_back(key_item(3, 32'hffff_fffe));
    pending_items.push_back(key_item(63, 32'hffff_ffff));
    wait_idle();
    write_count(7'd4);
    pending_items.push_back(sample_item(32'h0000_8000));
    pending_items.push_back(sample_item(32'h0000_0000));
    pending_items.push_back(sample_item(32'h8000_0000));
    pending_items.push_back(sample_item(32'hffff_fffe));
    pending_items.push_back(sample_item(32'hffff_ffff));
    pending_items.push_back(key_item(0, 32'h0002_0000));
    pending_items.push_back(sample_item(32'h0000_0001));
    pending_items.push_back(sample_item(32'h0001_8000));
    wait_idle();

    // random phases across key counts, the extremes among them
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: n_cur = 64;
        1: n_cur = 2;
        2: n_cur = 1;
        default: n_cur = $urandom_range(64, 2);
      endcase
      load_track(n_cur, ph % 3 == 0);
      wait_idle();
      if (ph == 5) write_count(7'd127);
      else if (ph == 7) write_count(7'd0);
      else write_count(7'(n_cur));
      for (int j = 0; j < 50; j++) begin
        if ($urandom_range(9) == 0) begin
          // reload a written key with the same time but new value
          pending_items.push_back(key_item($urandom_range(n_cur - 1), 32'd0));
          pending_items[$].time_value = trk_time_hint(pending_items[$].key_index);
        end else if ($urandom_range(4) == 0) begin
          pending_items.push_back(sample_item($urandom()));
        end else begin
          pending_items.push_back(sample_item(32'($urandom_range(last_span(n_cur)))));
        end
      end
      wait_idle();
      if (ph == 5 || ph == 7) write_count(7'(n_cur));
    end

    wait_idle();
    $display("ran %0d transfers, %0d samples checked over track sizes 1..64",
             items_sent, samples_seen);
    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire
